[src/gda_pkg.sv]
// Package for the Gregorian date adder: control word layout, the
// microprogram, calendar constants and the month length function.
// No dependencies.
package gda_pkg;

  localparam logic [13:0] MAX_YEAR = 14'd9999;
  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_DEC = 4'd12;
  localparam logic [4:0]  FEB_LEAP_LEN = 5'd29;

  // Reciprocal of 25 scaled by 2^17; exact quotient for any 14-bit year
  localparam logic [12:0] RECIP_25 = 13'd5243;
  localparam int          RECIP_SHIFT = 17;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef logic [2:0] upc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_ADDY,
    OP_MON,
    OP_CLAMP,
    OP_DAY,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_CNTZ,
    C_OUTFREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  t_addr;
    upc_t  f_addr;
  } uword_t;

  localparam upc_t PC_LOAD  = 3'd0;
  localparam upc_t PC_ADDY  = 3'd1;
  localparam upc_t PC_MON   = 3'd2;
  localparam upc_t PC_SETTLE = 3'd3;
  localparam upc_t PC_CLAMP = 3'd4;
  localparam upc_t PC_DAY   = 3'd5;
  localparam upc_t PC_EMIT  = 3'd6;

  // Microprogram: on a true condition go to t_addr, else to f_addr
  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, t_addr: PC_LOAD, f_addr: PC_LOAD};
    case (pc)
      PC_LOAD:   w = '{op: OP_LOAD,  cond: C_ACCEPT,  t_addr: PC_ADDY,   f_addr: PC_LOAD};
      PC_ADDY:   w = '{op: OP_ADDY,  cond: C_ALWAYS,  t_addr: PC_MON,    f_addr: PC_MON};
      PC_MON:    w = '{op: OP_MON,   cond: C_CNTZ,    t_addr: PC_SETTLE, f_addr: PC_MON};
      PC_SETTLE: w = '{op: OP_NOP,   cond: C_ALWAYS,  t_addr: PC_CLAMP,  f_addr: PC_CLAMP};
      PC_CLAMP:  w = '{op: OP_CLAMP, cond: C_ALWAYS,  t_addr: PC_DAY,    f_addr: PC_DAY};
      PC_DAY:    w = '{op: OP_DAY,   cond: C_CNTZ,    t_addr: PC_EMIT,   f_addr: PC_DAY};
      PC_EMIT:   w = '{op: OP_EMIT,  cond: C_OUTFREE, t_addr: PC_LOAD,   f_addr: PC_EMIT};
      default:   w = '{op: OP_NOP,   cond: C_ALWAYS,  t_addr: PC_LOAD,   f_addr: PC_LOAD};
    endcase
    return w;
  endfunction

  // Length of month m; leap selects the 29-day February
  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
    logic [3:0] idx;
    logic [4:0] len;
    idx = m - 4'd1;
    len = 5'd0;
    if (m == MONTH_FEB) begin
      len = leap ? FEB_LEAP_LEN : MONTH_LEN[idx];
    end else if (m >= MONTH_JAN && m <= MONTH_DEC) begin
      len = MONTH_LEN[idx];
    end
    return len;
  endfunction

endpackage

[src/gregorian_date_adder_top.sv]
// Gregorian date adder: microcoded sequencer over a small date datapath.
// Depends on gda_pkg (microprogram, constants, month length function).
//
//   channel | dir | ports                                   | transaction
//   --------+-----+-----------------------------------------+---------------------------
//   in_     | in  | start_year/month/day, add_years/months/ | valid high, stall low
//           |     | add_days                                |
//   out_    | out | result_year/month/day, year_overflow    | valid high, stall low
//
// A transaction runs load, year add, month loop, settle, clamp, day loop and
// emit from acceptance to a loaded result register; the month and day loops
// each advance one step per cycle through the single date datapath.
// A finished result sits in the output register while the next
// transaction is accepted. Synchronous active-low reset clears the step
// counter and output valid. in_stall is low only at the load step.
module gregorian_date_adder_top
  import gda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [13:0] in_start_year,
  input  logic [3:0]  in_start_month,
  input  logic [4:0]  in_start_day,
  input  logic [13:0] in_add_years,
  input  logic [11:0] in_add_months,
  input  logic [14:0] in_add_days,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_result_year,
  output logic [3:0]  out_result_month,
  output logic [4:0]  out_result_day,
  output logic        out_year_overflow
);

  upc_t        pc_r, pc_nxt;
  uword_t      uw;
  logic        cond_true;

  logic [13:0] y_r, y_nxt;
  logic [3:0]  m_r, m_nxt;
  logic [4:0]  d_r, d_nxt;
  logic        ovf_r, ovf_nxt;
  logic [13:0] ay_r, ay_nxt;
  logic [14:0] ad_r, ad_nxt;
  logic [14:0] cnt_r, cnt_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [13:0] oy_r, oy_nxt;
  logic [3:0]  om_r, om_nxt;
  logic [4:0]  od_r, od_nxt;
  logic        oovf_r, oovf_nxt;

  logic [26:0] leap_prod;
  logic [9:0]  lq_r;
  logic [13:0] ly_r;
  logic        leap_r, leap_nxt;
  logic [14:0] lq25;

  logic [4:0]  dim;
  logic [14:0] ysum;
  logic        accept;
  logic        cnt_zero;
  logic        out_free;

  // Decode the current control word
  assign uw        = ucode(pc_r);
  assign accept    = in_valid && (uw.op == OP_LOAD);
  assign in_stall  = (uw.op != OP_LOAD);
  assign cnt_zero  = (cnt_r == '0);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    case (uw.cond)
      C_ALWAYS:  cond_true = 1'b1;
      C_ACCEPT:  cond_true = accept;
      C_CNTZ:    cond_true = cnt_zero;
      C_OUTFREE: cond_true = out_free;
      default:   cond_true = 1'b1;
    endcase
    pc_nxt = cond_true ? uw.t_addr : uw.f_addr;
  end

  // Leap year pipeline: lq_r and ly_r sample the year register, then leap_r registers the result
  assign leap_prod = 27'(y_r) * 27'(RECIP_25);
  assign lq25      = 15'(lq_r) * 15'd25;
  assign leap_nxt  = (ly_r[1:0] == 2'b00) &&
                     ((ly_r != lq25[13:0]) || (ly_r[3:0] == 4'b0000));

  always_ff @(posedge clk) begin
    lq_r   <= leap_prod[26:RECIP_SHIFT];
    ly_r   <= y_r;
    leap_r <= leap_nxt;
  end

  assign dim  = days_in_month(m_r, leap_r);
  assign ysum = {1'b0, y_r} + {1'b0, ay_r};

  // Datapath actions per control word
  always_comb begin
    y_nxt   = y_r;
    m_nxt   = m_r;
    d_nxt   = d_r;
    ovf_nxt = ovf_r;
    ay_nxt  = ay_r;
    ad_nxt  = ad_r;
    cnt_nxt = cnt_r;
    case (uw.op)
      OP_LOAD: begin
        if (accept) begin
          ovf_nxt = 1'b0;
          y_nxt   = in_start_year;
          if (in_start_year == '0) begin
            y_nxt = 14'd1;
          end else if (in_start_year > MAX_YEAR) begin
            y_nxt   = MAX_YEAR;
            ovf_nxt = 1'b1;
          end
          m_nxt = in_start_month;
          if (in_start_month == '0) begin
            m_nxt = MONTH_JAN;
          end else if (in_start_month > MONTH_DEC) begin
            m_nxt = MONTH_DEC;
          end
          d_nxt   = (in_start_day == '0) ? 5'd1 : in_start_day;
          ay_nxt  = in_add_years;
          ad_nxt  = in_add_days;
          cnt_nxt = 15'(in_add_months);
        end
      end
      OP_ADDY: begin
        if (ysum > 15'(MAX_YEAR)) begin
          y_nxt   = MAX_YEAR;
          ovf_nxt = 1'b1;
        end else begin
          y_nxt = ysum[13:0];
        end
      end
      OP_MON: begin
        // advance one month, carrying into a saturating year
        if (!cnt_zero) begin
          cnt_nxt = cnt_r - 15'd1;
          if (m_r == MONTH_DEC) begin
            m_nxt = MONTH_JAN;
            if (y_r >= MAX_YEAR) begin
              ovf_nxt = 1'b1;
            end else begin
              y_nxt = y_r + 14'd1;
            end
          end else begin
            m_nxt = m_r + 4'd1;
          end
        end
      end
      OP_CLAMP: begin
        if (d_r > dim) begin
          d_nxt = dim;
        end
        cnt_nxt = ad_r;
      end
      OP_DAY: begin
        // advance one day; hold at the last representable date
        if (!cnt_zero) begin
          cnt_nxt = cnt_r - 15'd1;
          if (d_r >= dim) begin
            if (m_r == MONTH_DEC) begin
              if (y_r >= MAX_YEAR) begin
                ovf_nxt = 1'b1;
                cnt_nxt = '0;
              end else begin
                y_nxt = y_r + 14'd1;
                m_nxt = MONTH_JAN;
                d_nxt = 5'd1;
              end
            end else begin
              m_nxt = m_r + 4'd1;
              d_nxt = 5'd1;
            end
          end else begin
            d_nxt = d_r + 5'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: drop valid once taken, load when free
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    oy_nxt   = oy_r;
    om_nxt   = om_r;
    od_nxt   = od_r;
    oovf_nxt = oovf_r;
    if (uw.op == OP_EMIT && out_free) begin
      out_valid_nxt = 1'b1;
      oy_nxt   = y_r;
      om_nxt   = m_r;
      od_nxt   = d_r;
      oovf_nxt = ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    y_r    <= y_nxt;
    m_r    <= m_nxt;
    d_r    <= d_nxt;
    ovf_r  <= ovf_nxt;
    ay_r   <= ay_nxt;
    ad_r   <= ad_nxt;
    cnt_r  <= cnt_nxt;
    oy_r   <= oy_nxt;
    om_r   <= om_nxt;
    od_r   <= od_nxt;
    oovf_r <= oovf_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_result_year   = oy_r;
  assign out_result_month  = om_r;
  assign out_result_day    = od_r;
  assign out_year_overflow = oovf_r;

endmodule
